>>> hw/rtl/rcp_pkg.sv
// Shared types and constants for the RoQ chunk parser with DPCM sound decode.
// No dependencies; imported by every module under hw/rtl.
`timescale 1ns / 1ps

package rcp_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_FILE    = 2'd0,
        PH_CHUNK   = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_HALT    = 2'd3
    } rcp_phase_t;

    // How payload bytes of the current chunk are handled
    typedef enum logic [1:0] {
        KIND_SKIP   = 2'd0,
        KIND_MONO   = 2'd1,
        KIND_STEREO = 2'd2
    } rcp_kind_t;

    // Result event codes
    typedef enum logic [2:0] {
        EV_FILE_OK  = 3'd0,
        EV_HEADER   = 3'd1,
        EV_MONO     = 3'd2,
        EV_LEFT     = 3'd3,
        EV_RIGHT    = 3'd4,
        EV_BADSIG   = 3'd5,
        EV_OVERSIZE = 3'd6
    } rcp_event_t;

    // Restart codes on the input side; the fourth code acts as continue
    localparam logic [1:0] RS_CONTINUE = 2'd0;
    localparam logic [1:0] RS_NEW_FILE = 2'd1;
    localparam logic [1:0] RS_LOOP     = 2'd2;

    localparam logic [15:0] SIG_ID          = 16'h1084;
    localparam logic [31:0] SIG_SIZE        = 32'hFFFF_FFFF;
    localparam logic [15:0] ID_SOUND_MONO   = 16'h1020;
    localparam logic [15:0] ID_SOUND_STEREO = 16'h1021;
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd65536;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] restart;
    } rcp_item_t;

    typedef struct packed {
        rcp_event_t  event_res;
        logic [15:0] sample;
        logic [15:0] block_id;
        logic [31:0] block_size;
        logic [15:0] block_arg;
    } rcp_result_t;

    // Handshake between the pipeline stages
    typedef struct packed {
        logic in_valid;   // input register holds a byte
        logic advance;    // byte in the input register is processed this cycle
    } rcp_ctrl_t;

endpackage

>>> hw/rtl/rcp_in_stage.sv
// Input register of the RoQ parser: holds one accepted byte and its restart code.
// Depends on rcp_pkg.
`timescale 1ns / 1ps

module rcp_in_stage import rcp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  rcp_item_t s_item,
    input  logic      advance,
    output logic      in_valid,
    output rcp_item_t in_item
);

    logic      valid_reg;
    logic      valid_next;
    rcp_item_t item_reg;

    // Free, or emptying this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule

>>> hw/rtl/rcp_core.sv
// Parser state and per-byte work: header collection, checks, DPCM decode.
// Depends on rcp_pkg.
`timescale 1ns / 1ps

module rcp_core import rcp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  rcp_ctrl_t   ctrl,
    input  rcp_item_t   item,
    input  logic [31:0] max_payload,
    output logic        res_valid,
    output rcp_result_t res
);

    rcp_phase_t  phase_reg, phase_next, phase_eff;
    rcp_kind_t   kind_reg, kind_next;
    logic [2:0]  idx_reg, idx_next, idx_eff;
    logic [63:0] hb_reg, hb_next;
    logic [31:0] left_cnt_reg, left_cnt_next;
    logic        toggle_reg, toggle_next;
    logic [15:0] lpred_reg, lpred_next;
    logic [15:0] rpred_reg, rpred_next;

    logic [63:0] hdr;
    logic [15:0] hdr_id;
    logic [31:0] hdr_size;
    logic [15:0] hdr_arg;
    logic [15:0] delta;
    logic        step;

    assign step = ctrl.advance;

    // Square-table delta: b*b below 128, else -((b-128)^2)
    function automatic logic [15:0] dpcm_delta(input logic [7:0] b);
        logic [13:0] sq;
        sq = b[6:0] * b[6:0];
        return b[7] ? (16'd0 - {2'b00, sq}) : {2'b00, sq};
    endfunction

    assign delta    = dpcm_delta(item.data_byte);
    assign hdr      = {item.data_byte, hb_reg[55:0]};
    assign hdr_id   = hdr[15:0];
    assign hdr_size = hdr[47:16];
    assign hdr_arg  = hdr[63:48];

    always_comb begin
        phase_eff = phase_reg;
        idx_eff   = idx_reg;
        case (item.restart)
            RS_NEW_FILE: begin
                phase_eff = PH_FILE;
                idx_eff   = 3'd0;
            end
            RS_LOOP: begin
                phase_eff = PH_CHUNK;
                idx_eff   = 3'd0;
            end
            default: begin
            end
        endcase

        phase_next    = phase_eff;
        idx_next      = idx_eff;
        hb_next       = hb_reg;
        kind_next     = kind_reg;
        left_cnt_next = left_cnt_reg;
        toggle_next   = toggle_reg;
        lpred_next    = lpred_reg;
        rpred_next    = rpred_reg;
        res_valid     = 1'b0;
        res           = '0;

        case (phase_eff)
            PH_HALT: begin
            end
            PH_PAYLOAD: begin
                left_cnt_next = left_cnt_reg - 32'd1;
                case (kind_reg)
                    KIND_MONO: begin
                        lpred_next    = lpred_reg + delta;
                        res_valid     = 1'b1;
                        res.event_res = EV_MONO;
                        res.sample    = lpred_next;
                    end
                    KIND_STEREO: begin
                        res_valid   = 1'b1;
                        toggle_next = !toggle_reg;
                        if (!toggle_reg) begin
                            lpred_next    = lpred_reg + delta;
                            res.event_res = EV_LEFT;
                            res.sample    = lpred_next;
                        end else begin
                            rpred_next    = rpred_reg + delta;
                            res.event_res = EV_RIGHT;
                            res.sample    = rpred_next;
                        end
                    end
                    default: begin
                    end
                endcase
                if (left_cnt_reg == 32'd1) begin
                    phase_next = PH_CHUNK;
                    idx_next   = 3'd0;
                end
            end
            default: begin
                // file or chunk header byte
                hb_next[{idx_eff, 3'b000} +: 8] = item.data_byte;
                idx_next = idx_eff + 3'd1;
                if (idx_eff == 3'd7) begin
                    res_valid      = 1'b1;
                    res.block_id   = hdr_id;
                    res.block_size = hdr_size;
                    res.block_arg  = hdr_arg;
                    if (phase_eff == PH_FILE) begin
                        if (hdr_id == SIG_ID && hdr_size == SIG_SIZE) begin
                            res.event_res = EV_FILE_OK;
                            phase_next    = PH_CHUNK;
                        end else begin
                            res.event_res = EV_BADSIG;
                            phase_next    = PH_HALT;
                        end
                    end else if (hdr_size > max_payload) begin
                        res.event_res = EV_OVERSIZE;
                        phase_next    = PH_HALT;
                    end else begin
                        res.event_res = EV_HEADER;
                        kind_next     = KIND_SKIP;
                        if (hdr_id == ID_SOUND_MONO) begin
                            kind_next  = KIND_MONO;
                            lpred_next = hdr_arg;
                        end else if (hdr_id == ID_SOUND_STEREO) begin
                            kind_next   = KIND_STEREO;
                            lpred_next  = {hdr_arg[15:8], 8'h00};
                            rpred_next  = {hdr_arg[7:0], 8'h00};
                            toggle_next = 1'b0;
                        end
                        if (hdr_size == 32'd0) begin
                            phase_next = PH_CHUNK;
                        end else begin
                            phase_next    = PH_PAYLOAD;
                            left_cnt_next = hdr_size;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FILE;
            idx_reg    <= 3'd0;
            kind_reg   <= KIND_SKIP;
            toggle_reg <= 1'b0;
            lpred_reg  <= 16'd0;
            rpred_reg  <= 16'd0;
        end else if (step) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            kind_reg   <= kind_next;
            toggle_reg <= toggle_next;
            lpred_reg  <= lpred_next;
            rpred_reg  <= rpred_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            hb_reg       <= hb_next;
            left_cnt_reg <= left_cnt_next;
        end
    end

    // Halted parser stays silent unless restarted
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PH_HALT && item.restart != RS_NEW_FILE
         && item.restart != RS_LOOP) |-> !res_valid)
        else $error("result produced while halted");

    // Partial header only while collecting a header
    a_idx_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != 3'd0) |-> (phase_reg == PH_FILE || phase_reg == PH_CHUNK))
        else $error("header index set outside header phase");

    // Payload phase always has bytes left
    a_payload_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (left_cnt_reg != 32'd0))
        else $error("payload phase with zero bytes left");

    // Nothing moves without a processed byte
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> ($stable(phase_reg) && $stable(lpred_reg) && $stable(rpred_reg)))
        else $error("parser state changed without a byte");

    // A byte is processed only when one is held
    a_step_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> ctrl.in_valid)
        else $error("byte processed from an empty input register");

endmodule

>>> hw/rtl/rcp_out_stage.sv
// Result register of the RoQ parser: holds one result until the sink takes it.
// Depends on rcp_pkg.
`timescale 1ns / 1ps

module rcp_out_stage import rcp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  rcp_result_t res,
    output logic        m_tvalid,
    input  logic        m_tready,
    output rcp_result_t m_res
);

    logic        valid_reg;
    logic        valid_next;
    rcp_result_t res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

>>> hw/rtl/roq_chunk_parser_dpcm_audio.sv
// Top level of the RoQ stream parser with square-table DPCM sound decode.
// Depends on rcp_pkg, rcp_in_stage, rcp_core, rcp_out_stage.
`timescale 1ns / 1ps

// The block takes a RoQ file one byte per input transfer. The first eight
// bytes are the file header (id 0x1084, size all ones, frame rate); a good
// header gives a "file ok" event, a bad one a "bad signature" event and the
// parser halts. After that each chunk header (16-bit id, 32-bit size, 16-bit
// argument, little-endian) gives a "chunk header" event, or an "oversize"
// event and a halt when the size exceeds cfg_data's max_payload register.
// Mono (0x1020) and stereo (0x1021) sound payload bytes give one decoded
// 16-bit sample each, left/right alternating in stereo; other payloads are
// skipped silently. A halted parser drops bytes until tuser carries a
// restart (1: new file, 2: loop to chunk header), which applies to the byte
// it arrives with. Rate: one byte per clock, sustained while m_tready is high.
// An accepted byte sits in the input register; a single pass through the
// header check / DPCM square-and-add then loads the result register when it
// is free or draining, and m_tvalid rises from that register. A stalled
// m_tready stops the input only once both registers are full. max_payload is
// to be written by the user only while the block is idle; it is not enforced.
module roq_chunk_parser_dpcm_audio import rcp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write: max_payload
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] restart
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [15:0] sample, [31:16] header id,
                                   // [63:32] header size, [79:64] header arg
    output logic [2:0]  m_tuser    // [2:0] event_res
);

    logic [31:0] max_payload_reg;
    rcp_item_t   s_item;
    rcp_item_t   in_item;
    rcp_ctrl_t   ctrl;
    logic        in_valid;
    logic        res_valid;
    rcp_result_t res;
    rcp_result_t m_res;

    // Register always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RST;
        end else if (cfg_valid && cfg_ready) begin
            max_payload_reg <= cfg_data;
        end
    end

    assign s_item.data_byte = s_tdata;
    assign s_item.restart   = s_tuser;

    // Process the held byte when the result register is free or draining
    assign ctrl.in_valid = in_valid;
    assign ctrl.advance  = in_valid && (!m_tvalid || m_tready);

    rcp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .advance  (ctrl.advance),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    rcp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .item        (in_item),
        .max_payload (max_payload_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    rcp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ctrl.advance && res_valid),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {m_res.block_arg, m_res.block_size, m_res.block_id, m_res.sample};
    assign m_tuser = m_res.event_res;

endmodule

>>> sim/roq_chunk_parser_dpcm_audio_test.sv
// Self-checking testbench for roq_chunk_parser_dpcm_audio: byte-stream driver,
// result monitor and a cycle-free predictor of the parser and DPCM decoder.
// Depends on rcp_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module roq_chunk_parser_dpcm_audio_test;
    import rcp_pkg::*;

    localparam logic [1:0] RS_UNUSED   = 2'd3;   // spare restart code, acts as continue
    localparam int         QUIET_LIMIT = 2000;   // cycles with no transfer anywhere
    localparam int         HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int         MAX_REPORTS = 100;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] data_byte
    logic [1:0]  s_tuser   = '0;   // [1:0] restart
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;          // [15:0] sample, [31:16] header id,
                                   // [63:32] header size, [79:64] header arg
    logic [2:0]  m_tuser;          // [2:0] event_res

    roq_chunk_parser_dpcm_audio dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Stimulus and bookkeeping
    rcp_item_t   stream_bytes[$];
    rcp_result_t expected_results[$];
    int          pushed_cnt     = 0;
    int          accepted_cnt   = 0;
    int          errors         = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_requests  = 0;
    int          hold_served    = 0;
    int          hold_left      = 0;
    int          quiet_cycles   = 0;

    // Predicted parser state
    rcp_phase_t  stream_phase = PH_FILE;
    logic [2:0]  hdr_count    = '0;
    logic [63:0] hdr_shift    = '0;
    logic [31:0] bytes_left   = '0;
    rcp_kind_t   payload_mode = KIND_SKIP;
    logic        on_right     = 1'b0;
    logic [15:0] left_acc     = '0;
    logic [15:0] right_acc    = '0;
    logic [31:0] size_limit   = MAX_PAYLOAD_RST;

    // Advances the predicted parser by one byte; returns 1 when a result is due.
    function automatic bit parse_byte(input logic [7:0] b, input logic [1:0] rs,
                                      output rcp_result_t r);
        logic [6:0]  mag;
        logic [15:0] delta;
        logic [15:0] id;
        logic [15:0] arg;
        logic [31:0] size;
        r = '0;
        if (rs == RS_NEW_FILE || rs == RS_LOOP) begin
            stream_phase = (rs == RS_NEW_FILE) ? PH_FILE : PH_CHUNK;
            hdr_count    = '0;
            hdr_shift    = '0;
            bytes_left   = '0;
            payload_mode = KIND_SKIP;
        end
        if (stream_phase == PH_HALT)
            return 1'b0;

        if (stream_phase == PH_PAYLOAD) begin
            // square-table DPCM: low seven bits squared, top bit gives the sign
            mag   = b[6:0];
            delta = 16'(mag) * 16'(mag);
            if (b[7])
                delta = -delta;
            bytes_left = bytes_left - 32'd1;
            if (payload_mode == KIND_MONO) begin
                left_acc    = left_acc + delta;
                r.event_res = EV_MONO;
                r.sample    = left_acc;
            end else if (payload_mode == KIND_STEREO) begin
                if (!on_right) begin
                    left_acc    = left_acc + delta;
                    r.event_res = EV_LEFT;
                    r.sample    = left_acc;
                end else begin
                    right_acc   = right_acc + delta;
                    r.event_res = EV_RIGHT;
                    r.sample    = right_acc;
                end
                on_right = ~on_right;
            end
            if (bytes_left == 0) begin
                stream_phase = PH_CHUNK;
                hdr_count    = '0;
                hdr_shift    = '0;
            end
            return payload_mode != KIND_SKIP;
        end

        // header collection, little-endian
        hdr_shift[{hdr_count, 3'b000} +: 8] = b;
        hdr_count = hdr_count + 3'd1;
        if (hdr_count != 0)
            return 1'b0;

        id           = hdr_shift[15:0];
        size         = hdr_shift[47:16];
        arg          = hdr_shift[63:48];
        hdr_shift    = '0;
        r.block_id   = id;
        r.block_size = size;
        r.block_arg  = arg;

        if (stream_phase == PH_FILE) begin
            if (id == SIG_ID && size == SIG_SIZE) begin
                r.event_res  = EV_FILE_OK;
                stream_phase = PH_CHUNK;
            end else begin
                r.event_res  = EV_BADSIG;
                stream_phase = PH_HALT;
            end
            return 1'b1;
        end

        if (size > size_limit) begin
            r.event_res  = EV_OVERSIZE;
            stream_phase = PH_HALT;
            return 1'b1;
        end

        r.event_res  = EV_HEADER;
        payload_mode = KIND_SKIP;
        if (id == ID_SOUND_MONO) begin
            payload_mode = KIND_MONO;
            left_acc     = arg;
        end else if (id == ID_SOUND_STEREO) begin
            payload_mode = KIND_STEREO;
            left_acc     = {arg[15:8], 8'h00};
            right_acc    = {arg[7:0], 8'h00};
            on_right     = 1'b0;
        end
        if (size == 0) begin
            stream_phase = PH_CHUNK;
        end else begin
            stream_phase = PH_PAYLOAD;
            bytes_left   = size;
        end
        return 1'b1;
    endfunction

    // Driver: one byte per transfer, predicted at the edge it is taken.
    always @(posedge aclk) begin
        rcp_result_t due;
        rcp_item_t   nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accepted_cnt++;
                if (parse_byte(s_tdata, s_tuser, due))
                    expected_results.push_back(due);
            end
            if (!s_tvalid || s_tready) begin
                if (stream_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = stream_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data_byte;
                    s_tuser  <= nxt.restart;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want_v,
                         got_v);
        end
    endtask

    // Monitor: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        rcp_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result: expected none, got event %0d data %h",
                                 $time, m_tuser, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(m_tuser));
                    check_field("sample", 32'(want.sample), 32'(m_tdata[15:0]));
                    check_field("block_id", 32'(want.block_id), 32'(m_tdata[31:16]));
                    check_field("block_size", want.block_size, m_tdata[63:32]);
                    check_field("block_arg", 32'(want.block_arg), 32'(m_tdata[79:64]));
                end
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[roq_chunk_parser_dpcm_audio] ERROR");
            $finish;
        end
    end

    // Stimulus helpers
    task automatic put(input logic [7:0] b, input logic [1:0] rs);
        rcp_item_t it;
        it.data_byte = b;
        it.restart   = rs;
        stream_bytes.push_back(it);
        pushed_cnt++;
    endtask

    function automatic logic [1:0] cont_code();
        return ($urandom_range(19) == 0) ? RS_UNUSED : RS_CONTINUE;
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] edges[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(4) == 0)
            return edges[$urandom_range(3)];
        return 8'($urandom_range(255));
    endfunction

    // 8-byte header; the restart code rides on the first byte
    task automatic put_header(input logic [15:0] id, input logic [31:0] size,
                              input logic [15:0] arg, input logic [1:0] rs);
        logic [63:0] raw;
        raw = {arg, size, id};
        put(raw[7:0], rs);
        for (int k = 1; k < 8; k++)
            put(raw[8*k +: 8], cont_code());
    endtask

    // Mostly well-formed chunk sequences, with stray bytes, corrupt file
    // headers, oversize chunks and payloads cut short by a restart.
    task automatic gen_stream(input int n, input logic [31:0] limit);
        int          start;
        int          r;
        int          len;
        bit          resync;
        logic [15:0] id;
        logic [31:0] size;
        logic [1:0]  rs;
        start  = pushed_cnt;
        resync = 1'b0;
        put_header(SIG_ID, SIG_SIZE, 16'($urandom_range(65535)), RS_NEW_FILE);
        while (pushed_cnt - start < n) begin
            r = $urandom_range(99);
            if (r < 4) begin
                repeat ($urandom_range(1, 3))
                    put(8'($urandom_range(255)), 2'($urandom_range(3)));
                resync = 1'b1;
            end else if (r < 12) begin
                id   = SIG_ID;
                size = SIG_SIZE;
                case ($urandom_range(3))
                    0: id   = id ^ (16'd1 << $urandom_range(15));
                    1: size = size ^ (32'd1 << $urandom_range(31));
                    default: ;
                endcase
                put_header(id, size, 16'($urandom_range(65535)), RS_NEW_FILE);
                resync = (id != SIG_ID || size != SIG_SIZE);
            end else begin
                r  = $urandom_range(99);
                id = (r < 40) ? ID_SOUND_MONO :
                     (r < 80) ? ID_SOUND_STEREO : 16'($urandom_range(65535));
                r = $urandom_range(99);
                if (r < 70)
                    size = $urandom_range(12);
                else if (r < 78)
                    size = $urandom_range(40, 13);
                else if (r < 90 && limit != 32'hFFFF_FFFF)
                    size = limit + 1 + $urandom_range(3);
                else
                    size = $urandom;
                rs = (resync || $urandom_range(9) == 0) ? RS_LOOP : cont_code();
                put_header(id, size, 16'($urandom_range(65535)), rs);
                resync = 1'b0;
                if (size > limit) begin
                    resync = 1'b1;
                    repeat ($urandom_range(2))
                        put(pick_byte(), cont_code());   // dropped while halted
                end else begin
                    len = int'(size);
                    if (size > 40) begin
                        len    = $urandom_range(40);
                        resync = 1'b1;
                    end else if ($urandom_range(19) == 0) begin
                        len    = $urandom_range(len);
                        resync = 1'b1;
                    end
                    for (int k = 0; k < len; k++)
                        put(pick_byte(), cont_code());
                end
            end
        end
    endtask

    // Waits for all pending transfers and results, then for the pipeline.
    task automatic drain();
        while (accepted_cnt != pushed_cnt || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid  <= 1'b0;
        size_limit = v;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass at the reset limit, no idling
        put_header(SIG_ID, SIG_SIZE, 16'd30, RS_NEW_FILE);
        put_header(ID_SOUND_MONO, 32'd4, 16'h8000, RS_CONTINUE);
        put(8'h00, RS_CONTINUE);
        put(8'h7F, RS_CONTINUE);
        put(8'h80, RS_CONTINUE);
        put(8'hFF, RS_CONTINUE);
        // odd stereo payload ends on a left sample
        put_header(ID_SOUND_STEREO, 32'd3, 16'h12FF, RS_CONTINUE);
        put(8'h01, RS_CONTINUE);
        put(8'h81, RS_CONTINUE);
        put(8'hFF, RS_CONTINUE);
        // empty chunk, header started with the spare restart code
        put_header(16'hFFFF, 32'd0, 16'hFFFF, RS_UNUSED);
        put_header(16'h0000, 32'd2, 16'h0000, RS_CONTINUE);
        put(8'hAA, RS_CONTINUE);
        put(8'h55, RS_CONTINUE);
        // size at the limit is accepted; payload cut short by a loop restart
        put_header(ID_SOUND_MONO, MAX_PAYLOAD_RST, 16'h7FFF, RS_CONTINUE);
        put(8'h40, RS_CONTINUE);
        put_header(16'h1002, MAX_PAYLOAD_RST + 1, 16'h0001, RS_LOOP);
        put(8'h84, RS_CONTINUE);
        put(8'h10, RS_UNUSED);
        put_header(SIG_ID, 32'hFFFF_FFFE, 16'd15, RS_NEW_FILE);
        put_header(16'h1085, SIG_SIZE, 16'd15, RS_NEW_FILE);
        put_header(ID_SOUND_STEREO, 32'hFFFF_FFFF, 16'h0000, RS_LOOP);
        drain();

        // Limit zero: only empty chunks pass; sender mostly idle
        write_limit(32'd0);
        send_idle_pct = 86;
        gen_stream(125, 32'd0);
        drain();

        // No limit at all; receiver mostly stalled
        write_limit(32'hFFFF_FFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 86;
        gen_stream(125, 32'hFFFF_FFFF);
        drain();

        // Reset value again, light idling on both sides and a long hold-off
        write_limit(MAX_PAYLOAD_RST);
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        gen_stream(125, MAX_PAYLOAD_RST);
        hold_requests++;
        drain();

        // Small random limit, full rate
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_limit(32'($urandom_range(48)));
        gen_stream(125, size_limit);
        drain();
        repeat (20) @(posedge aclk);

        if (errors == 0 && expected_results.size() == 0)
            $display("[roq_chunk_parser_dpcm_audio] OK");
        else
            $display("[roq_chunk_parser_dpcm_audio] ERROR");
        $finish;
    end

endmodule
